/* sv/ppc_pkg.sv */
// Shared types and constants for the pseudo-pressure to chamber converter.
package ppc_pkg;

  localparam int SegW      = 3;
  localparam int InW       = 16;
  localparam int CoefW     = 16;
  localparam int LimW      = 10;
  localparam int NormW     = 32;
  localparam int Lim2W     = 2 * LimW;
  localparam int QuotW     = 32;
  localparam int DivSteps  = QuotW;
  localparam int RootW     = QuotW / 2;
  localparam int SqrtSteps = RootW;
  localparam int RemW      = RootW + 2;
  localparam int TermW     = InW + CoefW + 1;
  localparam int FactW     = RootW + 1;
  localparam int ProdW     = TermW + FactW + 1;
  localparam int FracBits  = 30;
  localparam int PresW     = 13;
  localparam int PresMax   = 8191;

  typedef enum logic [2:0] {
    REG_NORM_LIMIT = 3'd0,
    REG_COEF_A_X   = 3'd1,
    REG_COEF_A_Y   = 3'd2,
    REG_COEF_B_X   = 3'd3,
    REG_COEF_B_Y   = 3'd4,
    REG_COEF_C_X   = 3'd5,
    REG_COEF_C_Y   = 3'd6
  } ppc_reg_t;

  typedef struct packed {
    logic                    valid;
    logic [SegW-1:0]         seg;
    logic                    limited;
    logic signed [TermW-1:0] ta;
    logic signed [TermW-1:0] tb;
    logic signed [TermW-1:0] tc;
  } ppc_item_t;

endpackage

/* sv/ppc_div_cell.sv */
// One restoring-division cell: yields one quotient bit per cycle.
module ppc_div_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  ppc_pkg::ppc_item_t       item_in,
  input  logic [ppc_pkg::NormW-1:0] rem_in,
  input  logic [ppc_pkg::NormW-1:0] div_in,
  input  logic [ppc_pkg::QuotW-1:0] quo_in,
  output ppc_pkg::ppc_item_t       item_out,
  output logic [ppc_pkg::NormW-1:0] rem_out,
  output logic [ppc_pkg::NormW-1:0] div_out,
  output logic [ppc_pkg::QuotW-1:0] quo_out
);
  import ppc_pkg::*;

  logic [NormW:0] shifted;
  logic [NormW:0] diff;
  logic           fits;

  assign shifted = {rem_in, 1'b0};
  assign diff    = shifted - {1'b0, div_in};
  assign fits    = shifted >= {1'b0, div_in};

  always_ff @(posedge clk) begin
    item_out <= item_in;
    rem_out  <= fits ? diff[NormW-1:0] : shifted[NormW-1:0];
    quo_out  <= {quo_in[QuotW-2:0], fits};
    div_out  <= div_in;
    if (rst) begin
      item_out.valid <= 1'b0;
    end
  end

endmodule

/* sv/ppc_sqrt_cell.sv */
// One integer square-root cell: yields one root bit per cycle.
module ppc_sqrt_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  ppc_pkg::ppc_item_t       item_in,
  input  logic [ppc_pkg::QuotW-1:0] rad_in,
  input  logic [ppc_pkg::RemW-1:0]  rem_in,
  input  logic [ppc_pkg::RootW-1:0] root_in,
  output ppc_pkg::ppc_item_t       item_out,
  output logic [ppc_pkg::QuotW-1:0] rad_out,
  output logic [ppc_pkg::RemW-1:0]  rem_out,
  output logic [ppc_pkg::RootW-1:0] root_out
);
  import ppc_pkg::*;

  logic [RemW+1:0] cand;
  logic [RemW+1:0] trial;
  logic [RemW+1:0] diff;
  logic            fits;

  assign cand  = {rem_in, rad_in[QuotW-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign diff  = cand - trial;
  assign fits  = cand >= trial;

  always_ff @(posedge clk) begin
    item_out <= item_in;
    rem_out  <= fits ? diff[RemW-1:0] : cand[RemW-1:0];
    root_out <= {root_in[RootW-2:0], fits};
    rad_out  <= {rad_in[QuotW-3:0], 2'b00};
    if (rst) begin
      item_out.valid <= 1'b0;
    end
  end

endmodule

/* sv/ppc_mix.sv */
// Scale, shift to non-negative, round and saturate the three chamber values.
module ppc_mix (
  input  logic                      clk,
  input  logic                      rst,
  input  ppc_pkg::ppc_item_t        item_in,
  input  logic [ppc_pkg::RootW-1:0] root_in,
  output logic                      done,
  output logic [ppc_pkg::SegW-1:0]  seg,
  output logic [ppc_pkg::PresW-1:0] pres_a,
  output logic [ppc_pkg::PresW-1:0] pres_b,
  output logic [ppc_pkg::PresW-1:0] pres_c,
  output logic                      limited
);
  import ppc_pkg::*;

  localparam int HiW = ProdW - FracBits;

  logic [FactW-1:0]        fact;
  logic signed [FactW:0]   fact_s;
  logic                    m1_valid, m2_valid;
  logic [SegW-1:0]         m1_seg, m2_seg;
  logic                    m1_lim, m2_lim;
  logic signed [ProdW-1:0] m1_a, m1_b, m1_c;
  logic signed [ProdW-1:0] m2_a, m2_b, m2_c;
  logic signed [ProdW-1:0] mn;

  assign fact   = item_in.limited ? {1'b0, root_in} : {1'b1, {RootW{1'b0}}};
  assign fact_s = signed'({1'b0, fact});

  always_comb begin
    mn = m1_a;
    if (m1_b < mn) mn = m1_b;
    if (m1_c < mn) mn = m1_c;
  end

  function automatic logic [PresW-1:0] round_sat(input logic signed [ProdW-1:0] p);
    logic [ProdW-1:0] sum;
    logic [HiW-1:0]   hi;
    sum = ProdW'(p) + (ProdW'(1) << (FracBits - 1));
    hi  = sum[ProdW-1:FracBits];
    return (hi > HiW'(PresMax)) ? PresW'(PresMax) : hi[PresW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    // multiply by the scale factor
    m1_valid <= item_in.valid;
    m1_seg   <= item_in.seg;
    m1_lim   <= item_in.limited;
    m1_a     <= ProdW'(item_in.ta) * ProdW'(fact_s);
    m1_b     <= ProdW'(item_in.tb) * ProdW'(fact_s);
    m1_c     <= ProdW'(item_in.tc) * ProdW'(fact_s);
    // lift all three when any is negative
    m2_valid <= m1_valid;
    m2_seg   <= m1_seg;
    m2_lim   <= m1_lim;
    m2_a     <= (mn < 0) ? m1_a - mn : m1_a;
    m2_b     <= (mn < 0) ? m1_b - mn : m1_b;
    m2_c     <= (mn < 0) ? m1_c - mn : m1_c;
    // round half up and saturate
    done     <= m2_valid;
    seg      <= m2_seg;
    limited  <= m2_lim;
    pres_a   <= round_sat(m2_a);
    pres_b   <= round_sat(m2_b);
    pres_c   <= round_sat(m2_c);
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      done     <= 1'b0;
    end
  end

endmodule

/* sv/pseudo_pressure_to_chamber.sv */
// Top level: pseudo-pressure vector to three chamber pressures.
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+---------------------------
//  command  | start, busy, segment, pseudo_x, pseudo_y  | start high, busy low
//  result   | done, segment_out, pressure_a/b/c, ...    | done high (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid and cfg_ready high
//
// One command is taken every cycle; busy stays low. The pipeline holds
// two front stages, 32 division cells, 16 square-root cells and three stages
// in the output mixer. The division and root chains set the latency.
// Reset clears every valid bit and loads the register defaults.
// The receiver cannot stall: each result shows for one cycle only.
module pseudo_pressure_to_chamber (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ppc_pkg::SegW-1:0]  segment,
  input  logic signed [ppc_pkg::InW-1:0] pseudo_x,
  input  logic signed [ppc_pkg::InW-1:0] pseudo_y,
  output logic                      done,
  output logic [ppc_pkg::SegW-1:0]  segment_out,
  output logic [ppc_pkg::PresW-1:0] pressure_a,
  output logic [ppc_pkg::PresW-1:0] pressure_b,
  output logic [ppc_pkg::PresW-1:0] pressure_c,
  output logic                      was_limited,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [ppc_pkg::CoefW-1:0] cfg_data
);
  import ppc_pkg::*;

  // configuration registers
  logic [LimW-1:0]         norm_limit;
  logic signed [CoefW-1:0] coef_a_x, coef_a_y, coef_b_x, coef_b_y, coef_c_x, coef_c_y;

  // front stage 1: squares and coefficient products
  logic                    s1_valid;
  logic [SegW-1:0]         s1_seg;
  logic [NormW-1:0]        s1_norm;
  logic [Lim2W-1:0]        s1_lim2;
  logic signed [2*InW-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy;
  logic signed [2*InW-1:0] sq_x, sq_y;

  // cell chains
  ppc_item_t        div_item [0:DivSteps];
  logic [NormW-1:0] div_rem  [0:DivSteps];
  logic [NormW-1:0] div_div  [0:DivSteps];
  logic [QuotW-1:0] div_quo  [0:DivSteps];
  ppc_item_t        sq_item  [0:SqrtSteps];
  logic [QuotW-1:0] sq_rad   [0:SqrtSteps];
  logic [RemW-1:0]  sq_rem   [0:SqrtSteps];
  logic [RootW-1:0] sq_root  [0:SqrtSteps];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // take a register write
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_limit <= LimW'(500);
      coef_a_x   <= CoefW'(0);
      coef_a_y   <= -CoefW'(10923);
      coef_b_x   <= CoefW'(9459);
      coef_b_y   <= CoefW'(5461);
      coef_c_x   <= -CoefW'(9459);
      coef_c_y   <= CoefW'(5461);
    end else if (cfg_valid && cfg_ready) begin
      case (ppc_reg_t'(cfg_index))
        REG_NORM_LIMIT: norm_limit <= cfg_data[LimW-1:0];
        REG_COEF_A_X:   coef_a_x   <= cfg_data;
        REG_COEF_A_Y:   coef_a_y   <= cfg_data;
        REG_COEF_B_X:   coef_b_x   <= cfg_data;
        REG_COEF_B_Y:   coef_b_y   <= cfg_data;
        REG_COEF_C_X:   coef_c_x   <= cfg_data;
        REG_COEF_C_Y:   coef_c_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sq_x = (2*InW)'(pseudo_x) * (2*InW)'(pseudo_x);
  assign sq_y = (2*InW)'(pseudo_y) * (2*InW)'(pseudo_y);

  // stage 1: square norm, limit squared, and the six weight products
  always_ff @(posedge clk) begin
    s1_valid <= start && !busy;
    s1_seg   <= segment;
    s1_norm  <= NormW'(unsigned'(sq_x)) + NormW'(unsigned'(sq_y));
    s1_lim2  <= Lim2W'(norm_limit) * Lim2W'(norm_limit);
    s1_ax    <= (2*InW)'(coef_a_x) * (2*InW)'(pseudo_x);
    s1_ay    <= (2*InW)'(coef_a_y) * (2*InW)'(pseudo_y);
    s1_bx    <= (2*InW)'(coef_b_x) * (2*InW)'(pseudo_x);
    s1_by    <= (2*InW)'(coef_b_y) * (2*InW)'(pseudo_y);
    s1_cx    <= (2*InW)'(coef_c_x) * (2*InW)'(pseudo_x);
    s1_cy    <= (2*InW)'(coef_c_y) * (2*InW)'(pseudo_y);
    if (rst) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 2: decide limiting, sum the terms, and load the divider
  always_ff @(posedge clk) begin
    div_item[0].valid   <= s1_valid;
    div_item[0].seg     <= s1_seg;
    div_item[0].limited <= s1_norm > NormW'(s1_lim2);
    div_item[0].ta      <= TermW'(s1_ax) + TermW'(s1_ay);
    div_item[0].tb      <= TermW'(s1_bx) + TermW'(s1_by);
    div_item[0].tc      <= TermW'(s1_cx) + TermW'(s1_cy);
    div_rem[0]          <= NormW'(s1_lim2);
    div_div[0]          <= s1_norm;
    div_quo[0]          <= '0;
    if (rst) begin
      div_item[0].valid <= 1'b0;
    end
  end

  // quotient of limit squared times 2^32 over the norm, one bit per cell
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    ppc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .item_in  (div_item[i]),
      .rem_in   (div_rem[i]),
      .div_in   (div_div[i]),
      .quo_in   (div_quo[i]),
      .item_out (div_item[i+1]),
      .rem_out  (div_rem[i+1]),
      .div_out  (div_div[i+1]),
      .quo_out  (div_quo[i+1])
    );
  end

  assign sq_item[0] = div_item[DivSteps];
  assign sq_rad[0]  = div_quo[DivSteps];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  // square root of that quotient gives the scale factor
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    ppc_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .item_in  (sq_item[i]),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .item_out (sq_item[i+1]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
  end

  ppc_mix u_mix (
    .clk     (clk),
    .rst     (rst),
    .item_in (sq_item[SqrtSteps]),
    .root_in (sq_root[SqrtSteps]),
    .done    (done),
    .seg     (segment_out),
    .pres_a  (pressure_a),
    .pres_b  (pressure_b),
    .pres_c  (pressure_c),
    .limited (was_limited)
  );

endmodule

/* sim/pseudo_pressure_to_chamber_tb.sv */
// Testbench for the pseudo-pressure to chamber converter: directed and random commands.
`timescale 1ns / 1ps

module pseudo_pressure_to_chamber_tb;
  import ppc_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [2:0] RegNone = 3'd7;
  // Hold-off that exceeds the pipeline depth.
  localparam int Drain = 60;

  typedef struct {
    logic [SegW-1:0]  seg;
    logic [PresW-1:0] pa;
    logic [PresW-1:0] pb;
    logic [PresW-1:0] pc;
    logic             lim;
  } chamber_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [SegW-1:0] segment = '0;
  logic signed [InW-1:0] pseudo_x = '0;
  logic signed [InW-1:0] pseudo_y = '0;
  logic done;
  logic [SegW-1:0] segment_out;
  logic [PresW-1:0] pressure_a, pressure_b, pressure_c;
  logic was_limited;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CoefW-1:0] cfg_data = '0;

  // Local copy of the register file
  logic [LimW-1:0] limit_q;
  logic signed [CoefW-1:0] weight_q [6];

  chamber_t pending_chambers[$];
  int errors = 0;

  pseudo_pressure_to_chamber dut (.*);

  always #5 clk = ~clk;

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r = 0;
    for (int b = 31; b >= 0; b--) begin
      longint unsigned t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return longint'(r);
  endfunction

  function automatic logic [PresW-1:0] round_clip(longint p);
    longint r = (p + (64'sd1 <<< 29)) >>> FracBits;
    return (r > PresMax) ? PresW'(PresMax) : PresW'(r);
  endfunction

  // Expected chamber pressures for one command under the current registers
  function automatic chamber_t chamber_pressures(logic [SegW-1:0] seg,
                                                 logic signed [InW-1:0] x,
                                                 logic signed [InW-1:0] y);
    chamber_t c;
    longint xl = x, yl = y;
    longint unsigned n = xl * xl + yl * yl;
    longint unsigned l2 = longint'(limit_q) * longint'(limit_q);
    longint xs, ys, f, pa, pb, pc, mn;
    c.seg = seg;
    c.lim = n > l2;
    if (c.lim) begin
      f  = root_floor((l2 << 32) / n);
      xs = xl * f;
      ys = yl * f;
    end else begin
      xs = xl <<< 16;
      ys = yl <<< 16;
    end
    pa = longint'(weight_q[0]) * xs + longint'(weight_q[1]) * ys;
    pb = longint'(weight_q[2]) * xs + longint'(weight_q[3]) * ys;
    pc = longint'(weight_q[4]) * xs + longint'(weight_q[5]) * ys;
    mn = pa;
    if (pb < mn) mn = pb;
    if (pc < mn) mn = pc;
    // shift up so the lowest chamber sits at zero
    if (mn < 0) begin
      pa -= mn;
      pb -= mn;
      pc -= mn;
    end
    c.pa = round_clip(pa);
    c.pb = round_clip(pb);
    c.pc = round_clip(pc);
    return c;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Check each result against the oldest pending expectation
  always @(posedge clk) begin
    chamber_t e;
    if (!rst && done) begin
      if (pending_chambers.size() == 0) begin
        $display("%0t result with nothing pending", $time);
        errors++;
      end else begin
        e = pending_chambers.pop_front();
        if (segment_out !== e.seg) report("segment_out", 16'(segment_out), 16'(e.seg));
        if (pressure_a !== e.pa) report("pressure_a", 16'(pressure_a), 16'(e.pa));
        if (pressure_b !== e.pb) report("pressure_b", 16'(pressure_b), 16'(e.pb));
        if (pressure_c !== e.pc) report("pressure_c", 16'(pressure_c), 16'(e.pc));
        if (was_limited !== e.lim) report("was_limited", 16'(was_limited), 16'(e.lim));
      end
    end
  end

  // Offer one command after a random gap; start is only dropped when the gap is not zero
  task automatic send_command(logic [SegW-1:0] seg, logic signed [InW-1:0] x,
                              logic signed [InW-1:0] y);
    int gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    segment  <= seg;
    pseudo_x <= x;
    pseudo_y <= y;
    do @(posedge clk); while (busy);
    pending_chambers.push_back(chamber_pressures(seg, x, y));
  endtask

  // Drain the pipeline, then hold off for its depth before touching registers
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    wait (pending_chambers.size() == 0);
    repeat (Drain) @(posedge clk);
  endtask

  // One register write; valid drops for a cycle before the next transfer
  task automatic write_reg(logic [2:0] idx, logic [CoefW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_NORM_LIMIT) limit_q = val[LimW-1:0];
    else if (idx != RegNone) weight_q[idx - 1] = val;
    @(posedge clk);
  endtask

  task automatic load_defaults();
    write_reg(REG_NORM_LIMIT, 16'd500);
    write_reg(REG_COEF_A_X, 16'sd0);
    write_reg(REG_COEF_A_Y, -16'sd10923);
    write_reg(REG_COEF_B_X, 16'sd9459);
    write_reg(REG_COEF_B_Y, 16'sd5461);
    write_reg(REG_COEF_C_X, -16'sd9459);
    write_reg(REG_COEF_C_Y, 16'sd5461);
  endtask

  // Reset values: field extremes, zero vector, vector right on the limit, all segments
  task automatic test_directed();
    for (int s = 0; s < 8; s++) send_command(SegW'(s), 16'sd300, -16'sd400);
    send_command(3'd0, 16'sd0, 16'sd0);
    send_command(3'd1, 16'sd500, 16'sd0);
    send_command(3'd2, 16'sd0, -16'sd501);
    send_command(3'd3, 16'sh7FFF, 16'sh7FFF);
    send_command(3'd4, -16'sh8000, -16'sh8000);
    send_command(3'd5, -16'sh8000, 16'sh7FFF);
    send_command(3'd6, 16'sd1, -16'sd1);
    send_command(3'd7, -16'sd200, 16'sd100);
  endtask

  // Zero, smallest and largest limits; the unused index must be ignored
  task automatic test_limits();
    logic [LimW-1:0] lims [3] = '{10'd0, 10'd1, 10'd1023};
    foreach (lims[i]) begin
      settle();
      write_reg(REG_NORM_LIMIT, 16'(lims[i]));
      write_reg(RegNone, 16'hFFFF);
      send_command(3'd0, 16'sd0, 16'sd0);
      send_command(3'd1, 16'sd1, 16'sd0);
      send_command(3'd2, 16'sd1023, 16'sd0);
      send_command(3'd3, -16'sh8000, 16'sh7FFF);
    end
  endtask

  // Coefficient extremes drive the chambers into saturation
  task automatic test_weights();
    settle();
    write_reg(REG_NORM_LIMIT, 16'd1023);
    for (int r = REG_COEF_A_X; r <= REG_COEF_C_Y; r++)
      write_reg(3'(r), (r % 2) ? 16'h8000 : 16'h7FFF);
    send_command(3'd0, 16'sd1000, 16'sd1000);
    send_command(3'd1, -16'sd1000, 16'sd5);
    settle();
    for (int r = REG_COEF_A_X; r <= REG_COEF_C_Y; r++)
      write_reg(3'(r), (r % 2) ? 16'h7FFF : 16'h8000);
    send_command(3'd2, 16'sd700, -16'sd700);
  endtask

  // Random phases: new registers per phase after the first, which runs on the defaults; mostly small vectors
  task automatic test_random();
    logic signed [InW-1:0] x, y;
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      write_reg(REG_NORM_LIMIT, 16'($urandom_range(0, 1023)));
      for (int r = REG_COEF_A_X; r <= REG_COEF_C_Y; r++)
        write_reg(3'(r), (ph == 0) ? 16'(weight_q[r - 1]) : 16'($urandom));
      if (ph == 0) load_defaults();
      for (int i = 0; i < 100; i++) begin
        case ($urandom_range(0, 3))
          0: begin
            x = InW'($urandom);
            y = InW'($urandom);
          end
          1: begin
            x = InW'(int'($urandom_range(0, 2400)) - 1200);
            y = InW'(int'($urandom_range(0, 2400)) - 1200);
          end
          default: begin
            x = InW'(int'($urandom_range(0, 200)) - 100);
            y = InW'(int'($urandom_range(0, 200)) - 100);
          end
        endcase
        send_command(SegW'($urandom), x, y);
      end
    end
  endtask

  initial begin
    limit_q  = 10'd500;
    weight_q = '{16'sd0, -16'sd10923, 16'sd9459, 16'sd5461, -16'sd9459, 16'sd5461};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_weights();
    test_random();
    settle();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Generous cap on run time
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
sv/ppc_pkg.sv
sv/ppc_div_cell.sv
sv/ppc_sqrt_cell.sv
sv/ppc_mix.sv
sv/pseudo_pressure_to_chamber.sv
sim/pseudo_pressure_to_chamber_tb.sv
